FILE: hw/rtl/ali_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ali_pkg;

    // parser modes
    typedef enum logic [3:0] {
        MODE_START  = 4'd0,
        MODE_KEY    = 4'd1,
        MODE_PVAR   = 4'd2,
        MODE_PCLOSE = 4'd3,
        MODE_PDONE  = 4'd4,
        MODE_EQ     = 4'd5,
        MODE_TERM   = 4'd6,
        MODE_NUM    = 4'd7,
        MODE_AFTER  = 4'd8,
        MODE_REST   = 4'd9,
        MODE_ERR    = 4'd10
    } mode_t;

    // line result codes, also used as latched error codes
    typedef enum logic [1:0] {
        STATUS_ASSIGNED = 2'd0,
        STATUS_PRINTED  = 2'd1,
        STATUS_SYNTAX   = 2'd2,
        STATUS_UNDEF    = 2'd3
    } status_t;

    localparam int unsigned WORD_W    = 32;
    localparam int unsigned VAR_W     = 2;
    localparam int unsigned VAR_COUNT = 3;
    localparam int unsigned KEY_LEN   = 6;

    localparam logic [VAR_W-1:0] VAR_NONE = 2'd3;

    localparam logic [7:0] CHAR_X      = 8'h78;
    localparam logic [7:0] CHAR_Y      = 8'h79;
    localparam logic [7:0] CHAR_Z      = 8'h7A;
    localparam logic [7:0] CHAR_P      = 8'h50;
    localparam logic [7:0] CHAR_EQ     = 8'h3D;
    localparam logic [7:0] CHAR_PLUS   = 8'h2B;
    localparam logic [7:0] CHAR_MINUS  = 8'h2D;
    localparam logic [7:0] CHAR_RPAREN = 8'h29;
    localparam logic [7:0] CHAR_ZERO   = 8'h30;
    localparam logic [7:0] CHAR_NINE   = 8'h39;
    localparam logic [7:0] CHAR_SPACE  = 8'h20;
    localparam logic [7:0] CHAR_TAB    = 8'h09;
    localparam logic [7:0] CHAR_CR     = 8'h0D;

    // per-line parser state
    typedef struct packed {
        mode_t             mode;
        logic [2:0]        key_pos;
        logic [VAR_W-1:0]  target;
        logic [WORD_W-1:0] sum;
        logic [WORD_W-1:0] term;
        logic              subtract;
        logic              err_valid;
        status_t           err_code;
        logic [VAR_W-1:0]  err_var;
    } parse_state_t;

    // one line result
    typedef struct packed {
        status_t           status;
        logic [WORD_W-1:0] value;
        logic [VAR_W-1:0]  variable_id;
    } line_result_t;

    // variable store write request
    typedef struct packed {
        logic              en;
        logic [VAR_W-1:0]  idx;
        logic [WORD_W-1:0] data;
    } var_write_t;

    // characters of the print keyword
    function automatic logic [7:0] key_char(input logic [2:0] pos);
        logic [7:0] c;
        unique case (pos)
            3'd0:    c = 8'h50;
            3'd1:    c = 8'h52;
            3'd2:    c = 8'h49;
            3'd3:    c = 8'h4E;
            3'd4:    c = 8'h54;
            3'd5:    c = 8'h28;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic [VAR_W-1:0] var_code(input logic [7:0] c);
        logic [VAR_W-1:0] v;
        priority if (c == CHAR_X) v = 2'd0;
        else if (c == CHAR_Y)     v = 2'd1;
        else if (c == CHAR_Z)     v = 2'd2;
        else                      v = VAR_NONE;
        return v;
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/assignment_line_interpreter_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Line interpreter for assignments and prints over the variables x, y and z.
// One beat is one byte of a line or a line-end marker; the unit takes a beat
// every cycle unless stalled. Each byte updates the parser state in the cycle
// it is taken, and a line end loads its single result into the output
// register at the edge that takes it, so a result is offered in the cycle
// right after its line-end beat. A byte beat is taken even while a result
// waits on out_stall; only a line-end beat waits for a free output register.
// Variables start undefined after reset and no clearing pass is needed.
module assignment_line_interpreter_unit (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic [7:0]         character,
    input  wire logic               end_of_line,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic [1:0]              status,
    output logic signed [31:0]      value,
    output logic [1:0]              variable_id
);
    import ali_pkg::*;

    parse_state_t         state_reg;
    parse_state_t         state_next;
    line_result_t         result_next;
    line_result_t         result_reg;
    logic                 out_valid_reg;
    var_write_t           wr;
    var_write_t           wr_gated;
    logic [VAR_W-1:0]     rd_idx;
    logic [WORD_W-1:0]    rd_value;
    logic                 rd_defined;
    logic [VAR_COUNT-1:0] defined;
    logic                 in_accept;
    logic                 line_accept;

    // handshake
    assign in_stall    = out_valid_reg && out_stall && end_of_line;
    assign in_accept   = in_valid && !in_stall;
    assign line_accept = in_accept && end_of_line;

    ali_parser u_parser (
        .state       (state_reg),
        .character   (character),
        .end_of_line (end_of_line),
        .rd_value    (rd_value),
        .rd_defined  (rd_defined),
        .rd_idx      (rd_idx),
        .state_next  (state_next),
        .result      (result_next),
        .wr          (wr)
    );

    always_comb
    begin
        wr_gated    = wr;
        wr_gated.en = wr.en && line_accept;
    end

    ali_var_file u_var_file (
        .clk        (clk),
        .rst_n      (rst_n),
        .wr         (wr_gated),
        .rd_idx     (rd_idx),
        .rd_value   (rd_value),
        .rd_defined (rd_defined),
        .defined    (defined)
    );

    // parser state, all-zero is line start with no error
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
        end
        else if (in_accept)
        begin
            state_reg <= state_next;
        end
    end

    // output register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (line_accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // output register payload
    always_ff @(posedge clk)
    begin
        if (line_accept)
        begin
            result_reg <= result_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign status      = result_reg.status;
    assign value       = signed'(result_reg.value);
    assign variable_id = result_reg.variable_id;

    // line end returns the parser to line start with no error
    a_line_clear: assert property (@(posedge clk) disable iff (!rst_n)
        line_accept |=> (state_reg.mode == MODE_START) && !state_reg.err_valid)
        else $error("parser state not cleared after line end");

    // error mode always carries a latched error
    a_err_latched: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg.mode == MODE_ERR) |-> state_reg.err_valid)
        else $error("error mode without latched error");

    // a stored assignment leaves its variable defined
    a_write_defines: assert property (@(posedge clk) disable iff (!rst_n)
        wr_gated.en |=> defined[$past(wr_gated.idx)])
        else $error("assigned variable not marked defined");

    // value is zero unless printing
    a_value_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status != STATUS_PRINTED)) |-> (value == 0))
        else $error("value nonzero on non-print result");

    // variable id is zero unless reporting an undefined variable
    a_vid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status != STATUS_UNDEF)) |-> (variable_id == 2'd0))
        else $error("variable id nonzero on non-undefined result");

endmodule

`default_nettype wire

FILE: hw/rtl/ali_var_file.sv
`timescale 1ns / 1ps
`default_nettype none

module ali_var_file (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire ali_pkg::var_write_t         wr,
    input  wire logic [ali_pkg::VAR_W-1:0]   rd_idx,
    output logic [ali_pkg::WORD_W-1:0]       rd_value,
    output logic                             rd_defined,
    output logic [ali_pkg::VAR_COUNT-1:0]    defined
);
    import ali_pkg::*;

    logic [WORD_W-1:0]    values_reg [VAR_COUNT];
    logic [VAR_COUNT-1:0] defined_reg;
    logic                 rd_in_range;

    // variable values, read out whether or not the variable is defined
    always_ff @(posedge clk)
    begin
        if (wr.en && (wr.idx != VAR_NONE))
        begin
            values_reg[wr.idx] <= wr.data;
        end
    end

    // defined bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            defined_reg <= '0;
        end
        else if (wr.en && (wr.idx != VAR_NONE))
        begin
            defined_reg[wr.idx] <= 1'b1;
        end
    end

    // read port
    assign rd_in_range = (rd_idx != VAR_NONE);
    assign rd_value    = rd_in_range ? values_reg[rd_idx] : '0;
    assign rd_defined  = rd_in_range && defined_reg[rd_idx];
    assign defined     = defined_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/ali_parser.sv
`timescale 1ns / 1ps
`default_nettype none

module ali_parser (
    input  wire ali_pkg::parse_state_t       state,
    input  wire logic [7:0]                  character,
    input  wire logic                        end_of_line,
    input  wire logic [ali_pkg::WORD_W-1:0]  rd_value,
    input  wire logic                        rd_defined,
    output logic [ali_pkg::VAR_W-1:0]        rd_idx,
    output ali_pkg::parse_state_t            state_next,
    output ali_pkg::line_result_t            result,
    output ali_pkg::var_write_t              wr
);
    import ali_pkg::*;

    logic [VAR_W-1:0]  v;
    logic              is_var;
    logic              is_digit;
    logic              is_blank;
    logic              is_op;
    logic [WORD_W-1:0] digit;
    logic [WORD_W-1:0] operand;
    logic [WORD_W-1:0] applied_sum;
    logic [WORD_W-1:0] term_times_ten;
    parse_state_t      clear_state;

    // character classes
    assign v        = var_code(character);
    assign is_var   = (v != VAR_NONE);
    assign is_digit = (character >= CHAR_ZERO) && (character <= CHAR_NINE);
    assign is_blank = (character == CHAR_SPACE) ||
                      ((character >= CHAR_TAB) && (character <= CHAR_CR));
    assign is_op    = (character == CHAR_PLUS) || (character == CHAR_MINUS);
    assign digit    = {{(WORD_W-8){1'b0}}, character - CHAR_ZERO};

    // variable lookup: print target at line end, term variable otherwise
    assign rd_idx = end_of_line ? state.target : v;

    // term accumulate and apply
    assign term_times_ten = (state.term << 3) + (state.term << 1);
    assign operand        = (state.mode == MODE_TERM) ? rd_value : state.term;
    assign applied_sum    = state.subtract ? (state.sum - operand) : (state.sum + operand);

    always_comb
    begin
        clear_state          = '0;
        clear_state.mode     = MODE_START;
        clear_state.err_code = STATUS_ASSIGNED;
    end

    // next parser state
    always_comb
    begin
        state_next = state;
        if (end_of_line)
        begin
            state_next = clear_state;
        end
        else if (!is_blank)
        begin
            unique case (state.mode)
                MODE_START:
                begin
                    if (is_var)
                    begin
                        state_next.target = v;
                        state_next.mode   = MODE_EQ;
                    end
                    else if (character == CHAR_P)
                    begin
                        state_next.key_pos = 3'd1;
                        state_next.mode    = MODE_KEY;
                    end
                    else
                    begin
                        state_next.err_valid = 1'b1;
                        state_next.err_code  = STATUS_SYNTAX;
                        state_next.mode      = MODE_ERR;
                    end
                end
                MODE_KEY:
                begin
                    if ((state.key_pos < 3'(KEY_LEN)) && (character == key_char(state.key_pos)))
                    begin
                        state_next.key_pos = state.key_pos + 3'd1;
                        if (state.key_pos == 3'(KEY_LEN - 1))
                        begin
                            state_next.mode = MODE_PVAR;
                        end
                    end
                    else
                    begin
                        state_next.err_valid = 1'b1;
                        state_next.err_code  = STATUS_SYNTAX;
                        state_next.mode      = MODE_ERR;
                    end
                end
                MODE_PVAR:
                begin
                    if (is_var)
                    begin
                        state_next.target = v;
                        state_next.mode   = MODE_PCLOSE;
                    end
                    else
                    begin
                        state_next.err_valid = 1'b1;
                        state_next.err_code  = STATUS_SYNTAX;
                        state_next.mode      = MODE_ERR;
                    end
                end
                MODE_PCLOSE:
                begin
                    if (character == CHAR_RPAREN)
                    begin
                        state_next.mode = MODE_PDONE;
                    end
                    else
                    begin
                        state_next.err_valid = 1'b1;
                        state_next.err_code  = STATUS_SYNTAX;
                        state_next.mode      = MODE_ERR;
                    end
                end
                MODE_PDONE:
                begin
                    state_next.err_valid = 1'b1;
                    state_next.err_code  = STATUS_SYNTAX;
                    state_next.mode      = MODE_ERR;
                end
                MODE_EQ:
                begin
                    if (character == CHAR_EQ)
                    begin
                        state_next.mode = MODE_TERM;
                    end
                    else
                    begin
                        state_next.err_valid = 1'b1;
                        state_next.err_code  = STATUS_SYNTAX;
                        state_next.mode      = MODE_ERR;
                    end
                end
                MODE_TERM:
                begin
                    if (is_var)
                    begin
                        if (rd_defined)
                        begin
                            state_next.sum      = applied_sum;
                            state_next.term     = '0;
                            state_next.subtract = 1'b0;
                            state_next.mode     = MODE_AFTER;
                        end
                        else
                        begin
                            state_next.err_valid = 1'b1;
                            state_next.err_code  = STATUS_UNDEF;
                            state_next.err_var   = v;
                            state_next.mode      = MODE_ERR;
                        end
                    end
                    else if (is_digit)
                    begin
                        state_next.term = digit;
                        state_next.mode = MODE_NUM;
                    end
                    else
                    begin
                        state_next.err_valid = 1'b1;
                        state_next.err_code  = STATUS_SYNTAX;
                        state_next.mode      = MODE_ERR;
                    end
                end
                MODE_NUM:
                begin
                    if (is_digit)
                    begin
                        state_next.term = term_times_ten + digit;
                    end
                    else
                    begin
                        state_next.sum      = applied_sum;
                        state_next.term     = '0;
                        state_next.subtract = (character == CHAR_MINUS);
                        state_next.mode     = is_op ? MODE_TERM : MODE_REST;
                    end
                end
                MODE_AFTER:
                begin
                    state_next.subtract = (character == CHAR_MINUS);
                    state_next.mode     = is_op ? MODE_TERM : MODE_REST;
                end
                default:
                begin
                    state_next = state;
                end
            endcase
        end
    end

    // line result and variable write at line end
    always_comb
    begin
        result.status      = STATUS_SYNTAX;
        result.value       = '0;
        result.variable_id = '0;
        wr.en              = 1'b0;
        wr.idx             = state.target;
        wr.data            = state.sum;
        unique case (state.mode)
            MODE_PDONE:
            begin
                if (rd_defined)
                begin
                    result.status = STATUS_PRINTED;
                    result.value  = rd_value;
                end
                else
                begin
                    result.status      = STATUS_UNDEF;
                    result.variable_id = state.target;
                end
            end
            MODE_NUM, MODE_AFTER, MODE_REST:
            begin
                if (state.target != VAR_NONE)
                begin
                    result.status = STATUS_ASSIGNED;
                    wr.en         = end_of_line;
                end
                if (state.mode == MODE_NUM)
                begin
                    wr.data = applied_sum;
                end
            end
            MODE_ERR:
            begin
                if (state.err_valid && (state.err_code == STATUS_UNDEF))
                begin
                    result.status      = STATUS_UNDEF;
                    result.variable_id = state.err_var;
                end
            end
            default:
            begin
                result.status = STATUS_SYNTAX;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: test/assignment_line_interpreter_unit_tb.sv
`timescale 1ns / 1ps

module assignment_line_interpreter_unit_tb;

    import ali_pkg::*;

    localparam logic [47:0] PRINT_WORD = "PRINT(";

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic [7:0]         character = 8'h00;
    logic               end_of_line = 1'b0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic [1:0]         status;
    logic signed [31:0] value;
    logic [1:0]         variable_id;

    // interpreter state mirrored in the bench
    logic [WORD_W-1:0]    var_value [VAR_COUNT];
    logic [VAR_COUNT-1:0] var_defined;
    mode_t                p_mode;
    int                   key_pos;
    logic [VAR_W-1:0]     target_var;
    logic [WORD_W-1:0]    acc_sum;
    logic [WORD_W-1:0]    acc_term;
    logic                 minus_pending;
    status_t              err_code;
    logic [VAR_W-1:0]     err_var;

    line_result_t awaited_lines [$];
    logic [7:0]   line_bytes [$];
    int           mismatches = 0;
    int           beats_sent = 0;
    int           burst_left = 0;
    int           stall_left = 0;
    int           stall_style = 0;

    assignment_line_interpreter_unit u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .character   (character),
        .end_of_line (end_of_line),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .status      (status),
        .value       (value),
        .variable_id (variable_id)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // per-line parse state back to its idle values
    task clear_line_state;
        p_mode        = MODE_START;
        key_pos       = 0;
        target_var    = '0;
        acc_sum       = '0;
        acc_term      = '0;
        minus_pending = 1'b0;
        err_code      = STATUS_ASSIGNED;
        err_var       = '0;
    endtask

    task mark_error(input status_t code, input logic [VAR_W-1:0] which);
        err_code = code;
        err_var  = which;
        p_mode   = MODE_ERR;
    endtask

    // add or subtract the finished term
    task fold_term;
        if (minus_pending)
            acc_sum = acc_sum - acc_term;
        else
            acc_sum = acc_sum + acc_term;
        acc_term      = '0;
        minus_pending = 1'b0;
    endtask

    // an operator continues the expression, anything else ends it
    task next_after_term(input logic [7:0] ch);
        if (ch == CHAR_PLUS || ch == CHAR_MINUS)
        begin
            minus_pending = (ch == CHAR_MINUS);
            p_mode        = MODE_TERM;
        end
        else
        begin
            p_mode = MODE_REST;
        end
    endtask

    // advance the mirrored parser by one beat, queue the line result at line end
    task interpret_beat(input logic [7:0] ch, input logic eol);
        line_result_t     res;
        logic [VAR_W-1:0] v;
        logic             digit;
        v = (ch == CHAR_X) ? 2'd0 : (ch == CHAR_Y) ? 2'd1 : (ch == CHAR_Z) ? 2'd2 : VAR_NONE;
        digit = (ch >= CHAR_ZERO) && (ch <= CHAR_NINE);
        if (!eol)
        begin
            // blanks never reach the parser
            if (ch == CHAR_SPACE || (ch >= CHAR_TAB && ch <= CHAR_CR))
                return;
            case (p_mode)
                MODE_START:
                begin
                    if (v != VAR_NONE)
                    begin
                        target_var = v;
                        p_mode     = MODE_EQ;
                    end
                    else if (ch == CHAR_P)
                    begin
                        key_pos = 1;
                        p_mode  = MODE_KEY;
                    end
                    else
                    begin
                        mark_error(STATUS_SYNTAX, '0);
                    end
                end
                MODE_KEY:
                begin
                    if (ch == PRINT_WORD[47 - 8 * key_pos -: 8])
                    begin
                        key_pos++;
                        if (key_pos == KEY_LEN)
                            p_mode = MODE_PVAR;
                    end
                    else
                    begin
                        mark_error(STATUS_SYNTAX, '0);
                    end
                end
                MODE_PVAR:
                begin
                    if (v != VAR_NONE)
                    begin
                        target_var = v;
                        p_mode     = MODE_PCLOSE;
                    end
                    else
                    begin
                        mark_error(STATUS_SYNTAX, '0);
                    end
                end
                MODE_PCLOSE:
                begin
                    if (ch == CHAR_RPAREN)
                        p_mode = MODE_PDONE;
                    else
                        mark_error(STATUS_SYNTAX, '0);
                end
                MODE_PDONE:
                begin
                    mark_error(STATUS_SYNTAX, '0);
                end
                MODE_EQ:
                begin
                    if (ch == CHAR_EQ)
                        p_mode = MODE_TERM;
                    else
                        mark_error(STATUS_SYNTAX, '0);
                end
                MODE_TERM:
                begin
                    if (v != VAR_NONE)
                    begin
                        if (var_defined[v])
                        begin
                            acc_term = var_value[v];
                            fold_term();
                            p_mode = MODE_AFTER;
                        end
                        else
                        begin
                            mark_error(STATUS_UNDEF, v);
                        end
                    end
                    else if (digit)
                    begin
                        acc_term = 32'(ch - CHAR_ZERO);
                        p_mode   = MODE_NUM;
                    end
                    else
                    begin
                        mark_error(STATUS_SYNTAX, '0);
                    end
                end
                MODE_NUM:
                begin
                    if (digit)
                    begin
                        acc_term = acc_term * 32'd10 + 32'(ch - CHAR_ZERO);
                    end
                    else
                    begin
                        fold_term();
                        next_after_term(ch);
                    end
                end
                MODE_AFTER:
                begin
                    next_after_term(ch);
                end
                default:
                begin
                end
            endcase
        end
        else
        begin
            res.status      = STATUS_SYNTAX;
            res.value       = '0;
            res.variable_id = '0;
            case (p_mode)
                MODE_PDONE:
                begin
                    if (var_defined[target_var])
                    begin
                        res.status = STATUS_PRINTED;
                        res.value  = var_value[target_var];
                    end
                    else
                    begin
                        res.status      = STATUS_UNDEF;
                        res.variable_id = target_var;
                    end
                end
                MODE_NUM, MODE_AFTER, MODE_REST:
                begin
                    if (p_mode == MODE_NUM)
                        fold_term();
                    var_value[target_var]   = acc_sum;
                    var_defined[target_var] = 1'b1;
                    res.status              = STATUS_ASSIGNED;
                end
                MODE_ERR:
                begin
                    res.status      = err_code;
                    res.variable_id = err_var;
                end
                default:
                begin
                end
            endcase
            awaited_lines.push_back(res);
            clear_line_state();
        end
    endtask

    // one input beat, with bursts and random gaps in between
    task send_beat(input logic [7:0] ch, input logic eol);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid    <= 1'b1;
        character   <= ch;
        end_of_line <= eol;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        interpret_beat(ch, eol);
        if (eol || !(ch == CHAR_SPACE || (ch >= CHAR_TAB && ch <= CHAR_CR)))
            beats_sent++;
    endtask

    // line end beats carry a random don't-care byte
    task send_line(input string text);
        int i;
        for (i = 0; i < text.len(); i++)
            send_beat(text[i], 1'b0);
        send_beat(8'($urandom_range(0, 255)), 1'b1);
    endtask

    task send_built_line;
        int i;
        for (i = 0; i < line_bytes.size(); i++)
            send_beat(line_bytes[i], 1'b0);
        send_beat(8'($urandom_range(0, 255)), 1'b1);
    endtask

    // hold the sender until every line result is back
    task wait_for_results;
        in_valid <= 1'b0;
        while (awaited_lines.size() != 0)
            @(posedge clk);
        @(posedge clk);
        burst_left = 0;
    endtask

    // byte of a built line, sometimes preceded by a blank
    task push_byte(input logic [7:0] ch);
        int r;
        if ($urandom_range(0, 6) == 0)
        begin
            r = $urandom_range(0, 5);
            line_bytes.push_back((r == 5) ? CHAR_SPACE : 8'(CHAR_TAB + r));
        end
        line_bytes.push_back(ch);
    endtask

    task build_assignment;
        int n_terms;
        int n_digits;
        push_byte(8'(CHAR_X + $urandom_range(0, 2)));
        push_byte(CHAR_EQ);
        n_terms = $urandom_range(1, 4);
        for (int t = 0; t < n_terms; t++)
        begin
            if (t > 0)
                push_byte($urandom_range(0, 1) ? CHAR_PLUS : CHAR_MINUS);
            if ($urandom_range(0, 9) < 4)
            begin
                push_byte(8'(CHAR_X + $urandom_range(0, 2)));
            end
            else
            begin
                // mostly short numbers, now and then long enough to wrap
                n_digits = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 14)
                                                       : $urandom_range(1, 4);
                repeat (n_digits) push_byte(8'(CHAR_ZERO + $urandom_range(0, 9)));
            end
        end
        // occasional trailing text after the expression
        if ($urandom_range(0, 4) == 0)
            repeat ($urandom_range(1, 5)) push_byte(8'($urandom_range(0, 255)));
    endtask

    task build_print;
        int i;
        for (i = 0; i < KEY_LEN; i++)
            push_byte(PRINT_WORD[47 - 8 * i -: 8]);
        push_byte(8'(CHAR_X + $urandom_range(0, 2)));
        push_byte(CHAR_RPAREN);
    endtask

    task test_empty_lines;
        send_line("");
        send_line("   ");
    endtask

    task test_undefined_variables;
        send_line("PRINT(x)");
        send_line("PRINT(z)");
        send_line("x=1+y");
        send_line("x=y+q");
        send_line("x=q+y");
        // failed assignment must not define x
        send_line("x=5+");
        send_line("PRINT(x)");
    endtask

    task test_assignments;
        send_line("x=5");
        send_line("PRINT(x)");
        send_line("y=x+4294967295");
        send_line("z=y-x-10");
        send_line("PRINT(z)");
        send_line("x=99999999999999");
        send_line("PRINT(x)");
        send_line("x=3;junk+");
        send_line("y=z+x)q");
        send_line("PRINT(y)");
    endtask

    task test_syntax_errors;
        send_line("PRT(x)");
        send_line("PRINT(x)y");
        send_line("PRINT(q)");
        send_line("PRINT(x");
        send_line("Px");
        send_line("x5");
        send_line("x=");
        send_line("x=5+*");
        send_line("a=1");
        send_line("9");
    endtask

    task test_blanks;
        int k;
        send_line(" y = x + 1 2 ");
        // every blank code, before and between the tokens
        line_bytes.delete();
        for (k = 0; k < 5; k++)
            line_bytes.push_back(8'(CHAR_TAB + k));
        line_bytes.push_back(CHAR_Z);
        line_bytes.push_back(CHAR_SPACE);
        line_bytes.push_back(CHAR_EQ);
        line_bytes.push_back(CHAR_TAB);
        line_bytes.push_back(CHAR_ZERO + 8'd7);
        send_built_line();
        send_line("PRINT (z)");
    endtask

    // mostly well-formed lines with random content, some broken, some noise
    task test_random_lines;
        int start_beats;
        int kind;
        int cut;
        start_beats = beats_sent;
        while (beats_sent - start_beats < 600)
        begin
            line_bytes.delete();
            kind = $urandom_range(0, 99);
            if (kind < 55)
            begin
                build_assignment();
            end
            else if (kind < 70)
            begin
                build_print();
            end
            else if (kind < 85)
            begin
                if (kind < 78)
                    build_assignment();
                else
                    build_print();
                cut = $urandom_range(0, line_bytes.size() - 1);
                if (kind % 2)
                begin
                    while (line_bytes.size() > cut)
                        void'(line_bytes.pop_back());
                end
                else
                begin
                    line_bytes[cut] = 8'($urandom_range(0, 255));
                end
            end
            else
            begin
                repeat ($urandom_range(0, 12)) line_bytes.push_back(8'($urandom_range(0, 255)));
            end
            send_built_line();
            if ($urandom_range(0, 39) == 0)
                wait_for_results();
        end
    endtask

    // receiver stall pattern: quiet, light and heavy stretches
    always @(posedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_style <= $urandom_range(0, 2);
            stall_left  <= $urandom_range(20, 200);
        end
        else
        begin
            stall_left <= stall_left - 1;
        end
        case (stall_style)
            0:       out_stall <= 1'b0;
            1:       out_stall <= ($urandom_range(0, 3) == 0);
            default: out_stall <= ($urandom_range(0, 9) < 7);
        endcase
    end

    // compare each result beat with the oldest queued line result
    always @(posedge clk)
    begin
        line_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (awaited_lines.size() == 0)
            begin
                if (mismatches < 10)
                    $display("unexpected result: status %0d value %0d id %0d",
                             status, value, variable_id);
                mismatches++;
            end
            else
            begin
                want = awaited_lines.pop_front();
                if (status !== want.status || value !== want.value
                    || variable_id !== want.variable_id)
                begin
                    if (mismatches < 10)
                        $display("mismatch: expected status %0d value %0d id %0d, got status %0d value %0d id %0d",
                                 want.status, $signed(want.value), want.variable_id,
                                 status, value, variable_id);
                    mismatches++;
                end
            end
        end
    end

    initial
    begin
        var_value[0] = '0;
        var_value[1] = '0;
        var_value[2] = '0;
        var_defined  = '0;
        clear_line_state();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_empty_lines();
        test_undefined_variables();
        test_assignments();
        wait_for_results();
        test_syntax_errors();
        test_blanks();
        wait_for_results();
        test_random_lines();
        wait_for_results();
        repeat (10) @(posedge clk);
        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // run limit
    initial
    begin
        #3000000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
